// ===== design/mfcrp_pkg.sv =====
// Shared types and constants of the marker-framed record parser.
`default_nettype none

package mfcrp_pkg;

    localparam int PAYLOAD_BYTES = 13;
    localparam int CNT_W         = 4;
    localparam int ID_BYTES      = 4;
    localparam int DATA_BYTES    = 8;
    localparam int LEN_IDX       = 12;
    localparam int MAX_LEN       = 8;
    localparam int PADDR_W       = 3;

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'h55;

    // Register select bit of paddr: register i lies at byte address 4*i.
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        PH_WAIT_START = 2'd0,
        PH_COLLECT    = 2'd1,
        PH_WAIT_END   = 2'd2
    } t_phase;

    typedef struct packed {
        logic shift;   // move the cell row one place and load the new byte
        logic emit;    // end marker matched: load the output register
    } t_ctrl;

endpackage

`default_nettype wire

// ===== design/mfcrp_if.sv =====
// Valid/ready channel interfaces for received bytes and parsed records.
`default_nettype none

interface mfcrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfcrp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_id;
    logic [63:0] frame_data;
    logic [3:0]  data_length;

    modport source (output valid, output frame_id, output frame_data,
                    output data_length, input ready);
    modport sink   (input valid, input frame_id, input frame_data,
                    input data_length, output ready);
endinterface

`default_nettype wire

// ===== design/mfcrp_cell.sv =====
// One payload byte cell of the shift row.
`default_nettype none

module mfcrp_cell (
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_byte
);

    logic [7:0] r_byte;

    // Take the neighbor's byte on a shift, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

// ===== design/mfcrp_ctrl.sv =====
// Frame phase sequencer: start/end marker checks and byte count.
`default_nettype none

module mfcrp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_byte,
    input  wire logic [7:0]       i_start_marker,
    input  wire logic [7:0]       i_end_marker,
    output mfcrp_pkg::t_ctrl      o_ctrl
);

    import mfcrp_pkg::*;

    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             is_start, is_end;

    assign is_start = (i_byte == i_start_marker);
    assign is_end   = (i_byte == i_end_marker);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_START;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (i_accept) begin
            unique case (r_phase)
                PH_COLLECT: begin
                    if (is_start) begin
                        n_cnt = '0;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                        if (r_cnt == CNT_W'(PAYLOAD_BYTES - 1)) begin
                            n_phase = PH_WAIT_END;
                        end
                    end
                end
                PH_WAIT_END: begin
                    n_phase = PH_WAIT_START;
                    n_cnt   = '0;
                end
                default: begin
                    if (is_start) begin
                        n_phase = PH_COLLECT;
                        n_cnt   = '0;
                    end else begin
                        n_phase = PH_WAIT_START;
                    end
                end
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_ctrl = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_COLLECT:  o_ctrl.shift = !is_start;
                PH_WAIT_END: o_ctrl.emit  = is_end;
                default:     o_ctrl = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/marker_framed_can_record_parser_core.sv =====
// Top level of the marker-framed CAN record parser.
`default_nettype none

// Takes one received byte per request on i_rx and accepts a byte in every
// cycle while the record output register is empty or being drained, so the
// sustained rate is one byte per cycle; a stalled record holds i_rx.ready low
// until o_rec.ready takes it. After the start marker the next 13 bytes shift
// through a row of 13 byte cells (new byte into the last cell, each cell
// handing its byte to its lower neighbor), so once the row is full cell k
// holds payload byte k. A start marker during collection restarts the count
// without storing the byte. The byte after the 13th payload byte is checked
// against the end marker: on a match one record leaves through o_rec in the
// next cycle (identifier from bytes 0-3 little-endian, data from bytes 4-11
// with byte 4 in the low bits, length from byte 12 saturated to 8); any other
// byte, the start marker included, drops the frame. Either way the parser
// goes back to hunting for the start marker. The markers are set over the
// APB port: start marker at address 0 (reset 0xAA), end marker at address 4
// (reset 0x55); write them only while the stream is idle.
module marker_framed_can_record_parser_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mfcrp_in_if.sink                         i_rx,
    mfcrp_out_if.source                      o_rec,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mfcrp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);

    import mfcrp_pkg::*;

    // Configuration registers
    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_START_MARKER: r_start_marker <= pwdata[7:0];
                REG_END_MARKER:   r_end_marker   <= pwdata[7:0];
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_START_MARKER: prdata = {24'd0, r_start_marker};
            REG_END_MARKER:   prdata = {24'd0, r_end_marker};
            default:          prdata = '0;
        endcase
    end

    // Input handshake: the output register frees up when drained this cycle.
    logic r_out_valid;
    logic accept;
    t_ctrl ctrl;

    assign i_rx.ready = !r_out_valid || o_rec.ready;
    assign accept     = i_rx.valid && i_rx.ready;

    mfcrp_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_rx.rx_byte),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .o_ctrl         (ctrl)
    );

    // Row of payload cells; the newest byte enters the top cell.
    logic [7:0] cell_q [PAYLOAD_BYTES];

    for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_cell
        logic [7:0] cell_d;
        if (k == PAYLOAD_BYTES - 1) begin : g_top
            assign cell_d = i_rx.rx_byte;
        end else begin : g_mid
            assign cell_d = cell_q[k+1];
        end
        mfcrp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (ctrl.shift),
            .i_byte  (cell_d),
            .o_byte  (cell_q[k])
        );
    end

    // Assemble the record from the full row.
    logic [31:0] rec_id;
    logic [63:0] rec_data;
    logic [3:0]  rec_len;

    always_comb begin
        for (int i = 0; i < ID_BYTES; i++) begin
            rec_id[8*i +: 8] = cell_q[i];
        end
        for (int i = 0; i < DATA_BYTES; i++) begin
            rec_data[8*i +: 8] = cell_q[ID_BYTES + i];
        end
        if (cell_q[LEN_IDX] > 8'(MAX_LEN)) begin
            rec_len = 4'(MAX_LEN);
        end else begin
            rec_len = cell_q[LEN_IDX][3:0];
        end
    end

    // Output register: load on a matched end marker, drop once taken.
    logic [31:0] r_out_id;
    logic [63:0] r_out_data;
    logic [3:0]  r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_id   <= rec_id;
            r_out_data <= rec_data;
            r_out_len  <= rec_len;
        end
    end

    assign o_rec.valid       = r_out_valid;
    assign o_rec.frame_id    = r_out_id;
    assign o_rec.frame_data  = r_out_data;
    assign o_rec.data_length = r_out_len;

endmodule

`default_nettype wire
